// ===== rtl/core/rlt_pkg.sv =====
// Shared types and codes of the row lock table.
// Used by rlt_ctrl, rlt_dp and the top level; depends on nothing.
package rlt_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_EXCL    = 2'd0;
    localparam logic [1:0] OP_SHARED  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;  // unassigned opcode, dropped

    // Result status codes.
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_DEADLOCK = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_WALK,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a request and restart the slot counter
        logic rd;      // read the slot at the counter and advance
        logic drain;   // last slot in flight; release clears wait edges
        logic decide;  // resolve an acquire against the scan result
        logic walk;    // one step along the wait-for chain
        logic emit;    // copy the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_ok;     // incoming request is a valid opcode and transaction
        logic op_rel;     // captured request is a release
        logic scan_last;  // counter points at the last slot
        logic found;      // scan found the row
        logic clash;      // acquire conflicts with another holder
        logic walk_done;  // current walk step ends the walk
    } stat_t;

endpackage

// ===== rtl/core/rlt_ctrl.sv =====
// Controller state machine of the row lock table.
// Depends on rlt_pkg; drives rlt_dp through rlt_pkg::cmd_t.
module rlt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rlt_pkg::stat_t stat,
    output rlt_pkg::cmd_t  cmd
);

    rlt_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            rlt_pkg::S_IDLE:
            begin
                if (in_valid && stat.req_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = rlt_pkg::S_SCAN;
                end
            end
            rlt_pkg::S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = rlt_pkg::S_DRAIN;
                end
            end
            rlt_pkg::S_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = stat.op_rel ? rlt_pkg::S_FINISH : rlt_pkg::S_DECIDE;
            end
            rlt_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.clash ? rlt_pkg::S_WALK : rlt_pkg::S_FINISH;
            end
            rlt_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = rlt_pkg::S_FINISH;
                end
            end
            rlt_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rlt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rlt_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == rlt_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // A result appears only out of the finishing state.
    a_emit_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rlt_pkg::S_FINISH))
        else $error("result raised outside the finishing state");

    // A chain walk only follows a scan that found the row.
    a_walk_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlt_pkg::S_WALK) |-> stat.found)
        else $error("wait-for walk without a matching slot");

    // The scan leaves only through the drain cycle.
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlt_pkg::S_SCAN) |=>
            (state_reg == rlt_pkg::S_SCAN || state_reg == rlt_pkg::S_DRAIN))
        else $error("slot scan cut short");

endmodule

// ===== rtl/core/rlt_dp.sv =====
// Datapath of the row lock table: slot memory, wait-for edges, chain walk.
// Depends on rlt_pkg; sequenced by rlt_ctrl.
module rlt_dp #(
    parameter int LOCK_SLOTS = 64,
    parameter int TXN_COUNT  = 16,
    parameter int KEY_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     in_opcode,
    input  logic [31:0]    in_row_key,
    input  logic [3:0]     in_requester,
    input  rlt_pkg::cmd_t  cmd,
    output rlt_pkg::stat_t stat,
    output logic [2:0]     out_status,
    output logic [3:0]     out_blocking_holder
);

    localparam int SW = $clog2(LOCK_SLOTS);
    localparam int TW = $clog2(TXN_COUNT);
    localparam int MW = KEY_BITS + 1 + TXN_COUNT;

    // Slot memory holds key, exclusive flag and holder mask; valid bits are flops.
    logic [MW-1:0]         mem [LOCK_SLOTS];
    logic [LOCK_SLOTS-1:0] valid_reg;
    logic [MW-1:0]         rdata_reg;

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [TW-1:0]         req_reg;
    logic [SW-1:0]         idx_reg, rd_idx_reg;
    logic                  rd_vld_reg;
    logic                  found_reg, free_reg;
    logic [SW-1:0]         found_idx_reg, free_idx_reg;
    logic                  hit_excl_reg;
    logic [TXN_COUNT-1:0]  hit_holders_reg;

    logic [TXN_COUNT-1:0]  edge_vld_reg;
    logic [TW-1:0]         edge_tgt_reg [TXN_COUNT];
    logic [TW-1:0]         cur_reg, holder_reg;
    logic [TXN_COUNT-1:0]  seen_reg;
    logic [2:0]            res_status_reg, out_status_reg;
    logic [TW-1:0]         res_holder_reg, out_holder_reg;

    logic [63:0]           key_wide;
    logic [7:0]            req_wide, out_holder_wide;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  rd_excl;
    logic [TXN_COUNT-1:0]  rd_holders, rel_holders, rbit;
    logic [TXN_COUNT-1:0]  pick_mask, new_holders;
    logic [TW-1:0]         lowest;
    logic                  new_excl, clash;
    logic                  we;
    logic [SW-1:0]         waddr;
    logic [MW-1:0]         wdata;
    logic                  w_hit, w_stop;

    assign key_wide = {32'd0, in_row_key};
    assign req_wide = {4'd0, in_requester};
    assign rbit     = {{(TXN_COUNT-1){1'b0}}, 1'b1} << req_reg;
    assign {rd_key, rd_excl, rd_holders} = rdata_reg;
    assign rel_holders = rd_holders & ~rbit;

    // Acquire decision against the matching slot.
    always_comb
    begin
        clash       = 1'b0;
        new_excl    = hit_excl_reg;
        new_holders = hit_holders_reg;
        pick_mask   = hit_holders_reg;
        if (hit_excl_reg)
        begin
            clash = (hit_holders_reg != rbit);
        end
        else if (op_reg == rlt_pkg::OP_EXCL)
        begin
            if (hit_holders_reg == rbit)
            begin
                new_excl = 1'b1;
            end
            else
            begin
                clash     = 1'b1;
                pick_mask = hit_holders_reg & ~rbit;
            end
        end
        else
        begin
            new_holders = hit_holders_reg | rbit;
        end
    end

    // Lowest-numbered holder in the conflicting mask.
    always_comb
    begin
        lowest = '0;
        for (int i = TXN_COUNT - 1; i >= 0; i--)
        begin
            if (pick_mask[i])
            begin
                lowest = TW'(i);
            end
        end
    end

    // Memory write port: release write-back during the scan, else acquire update.
    always_comb
    begin
        we    = 1'b0;
        waddr = rd_idx_reg;
        wdata = {rd_key, rd_excl, rel_holders};
        if (rd_vld_reg && op_reg == rlt_pkg::OP_RELEASE && valid_reg[rd_idx_reg])
        begin
            we = 1'b1;
        end
        else if (cmd.decide && found_reg && !clash)
        begin
            we    = 1'b1;
            waddr = found_idx_reg;
            wdata = {key_reg, new_excl, new_holders};
        end
        else if (cmd.decide && !found_reg && free_reg)
        begin
            we    = 1'b1;
            waddr = free_idx_reg;
            wdata = {key_reg, (op_reg == rlt_pkg::OP_EXCL), rbit};
        end
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Wait-for walk step.
    assign w_hit  = (cur_reg == req_reg);
    assign w_stop = seen_reg[cur_reg] || !edge_vld_reg[cur_reg];

    // Request capture, scan bookkeeping and results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            key_reg <= key_wide[KEY_BITS-1:0];
            req_reg <= req_wide[TW-1:0];
        end
        if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.rd)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        rd_idx_reg <= idx_reg;
        if (cmd.load)
        begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (rd_vld_reg && op_reg != rlt_pkg::OP_RELEASE)
        begin
            if (valid_reg[rd_idx_reg] && rd_key == key_reg && !found_reg)
            begin
                found_reg       <= 1'b1;
                found_idx_reg   <= rd_idx_reg;
                hit_excl_reg    <= rd_excl;
                hit_holders_reg <= rd_holders;
            end
            if (!valid_reg[rd_idx_reg] && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.drain)
        begin
            res_status_reg <= rlt_pkg::ST_RELEASED;
            res_holder_reg <= '0;
        end
        if (cmd.decide)
        begin
            res_status_reg <= (found_reg || free_reg) ? rlt_pkg::ST_GRANTED : rlt_pkg::ST_FULL;
            res_holder_reg <= '0;
            holder_reg     <= lowest;
            cur_reg        <= lowest;
            seen_reg       <= '0;
        end
        if (cmd.walk)
        begin
            cur_reg            <= edge_tgt_reg[cur_reg];
            seen_reg[cur_reg]  <= 1'b1;
            res_holder_reg     <= holder_reg;
            res_status_reg     <= w_hit ? rlt_pkg::ST_DEADLOCK : rlt_pkg::ST_CONFLICT;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_holder_reg <= res_holder_reg;
        end
    end

    // Control flops: read pipeline, slot valid bits and wait edges.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            edge_vld_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd;
            if (rd_vld_reg && op_reg == rlt_pkg::OP_RELEASE && rel_holders == '0)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (cmd.decide && !found_reg && free_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.drain && op_reg == rlt_pkg::OP_RELEASE)
            begin
                for (int t = 0; t < TXN_COUNT; t++)
                begin
                    if (TW'(t) == req_reg || edge_tgt_reg[t] == req_reg)
                    begin
                        edge_vld_reg[t] <= 1'b0;
                    end
                end
            end
            if (cmd.walk && !w_hit && w_stop)
            begin
                edge_vld_reg[req_reg] <= 1'b1;
            end
        end
    end

    // Edge targets are payload.
    always_ff @(posedge clk)
    begin
        if (cmd.walk && !w_hit && w_stop)
        begin
            edge_tgt_reg[req_reg] <= holder_reg;
        end
    end

    assign stat.req_ok    = (in_opcode != rlt_pkg::OP_NONE) &&
                            ({4'd0, in_requester} < 8'(TXN_COUNT));
    assign stat.op_rel    = (op_reg == rlt_pkg::OP_RELEASE);
    assign stat.scan_last = (idx_reg == SW'(LOCK_SLOTS - 1));
    assign stat.found     = found_reg;
    assign stat.clash     = found_reg && clash;
    assign stat.walk_done = w_hit || w_stop;

    assign out_holder_wide     = {{(8-TW){1'b0}}, out_holder_reg};
    assign out_status          = out_status_reg;
    assign out_blocking_holder = out_holder_wide[3:0];

endmodule

// ===== rtl/core/row_lock_table_with_deadlock_check.sv =====
// Row lock table with wait-for deadlock check, top level.
// Depends on rlt_pkg, rlt_ctrl and rlt_dp.
//
// Usage: a request enters on the s_ channel and gives exactly one result on
// the m_ channel. A request with opcode 3 or a transaction number not below
// TXN_COUNT is taken and dropped without a result.
// Timing: the slot memory is swept one slot per cycle through its single read
// port, so every request sweeps all slots and ends the sweep in a drain step.
// An acquire then adds a decision step; a conflict adds a walk along the
// wait-for chain, which stops at the requester, at a missing edge or at a
// transaction already seen. A last step loads the result into the output register.
// One request is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so the next request is taken while
// a result waits; if the receiver stalls, the next result waits in the
// finishing step until the register frees.
// Reset clears all slot valid bits and wait edges at once; no clearing pass.
module row_lock_table_with_deadlock_check #(
    parameter int LOCK_SLOTS = 64,
    parameter int TXN_COUNT  = 16,
    parameter int KEY_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[1:0], row_key[33:2], requester[37:34], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[2:0], blocking_holder[6:3], zero
);

    rlt_pkg::cmd_t  cmd;
    rlt_pkg::stat_t stat;
    logic [2:0]     status;
    logic [3:0]     blocking_holder;

    // Sequencer.
    rlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Lock slots, wait edges and result registers.
    rlt_dp #(
        .LOCK_SLOTS (LOCK_SLOTS),
        .TXN_COUNT  (TXN_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_opcode           (s_tdata[1:0]),
        .in_row_key          (s_tdata[33:2]),
        .in_requester        (s_tdata[37:34]),
        .cmd                 (cmd),
        .stat                (stat),
        .out_status          (status),
        .out_blocking_holder (blocking_holder)
    );

    assign m_tdata = {1'b0, blocking_holder, status};

endmodule

// ===== bench/tb_row_lock_table_with_deadlock_check.sv =====
// Self-checking testbench of the row lock table with deadlock check.
// Depends on rlt_pkg and row_lock_table_with_deadlock_check; drives requests on s_ and
// compares every result on m_ against a lock-table predictor held in the bench.
module tb_row_lock_table_with_deadlock_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int TXNS = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] holder;
    } lock_answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    // Predictor state: slot table and wait-for edges.
    logic        slot_used [SLOTS];
    logic        slot_excl [SLOTS];
    logic [31:0] slot_key [SLOTS];
    logic [15:0] slot_holders [SLOTS];
    logic        edge_on [TXNS];
    logic [3:0]  edge_to [TXNS];

    lock_answer_t answers_due[$];
    int  fail_count;
    int  cycle_count;
    int  stall_left;
    bit  calm;
    // Keys used by the random part; a small pool makes rows collide often.
    logic [31:0] key_pool [8];

    row_lock_table_with_deadlock_check dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Walk the wait-for chain from the holder; true if it comes back to the requester.
    function automatic bit chain_reaches(logic [3:0] req, logic [3:0] start);
        logic [15:0] seen;
        logic [3:0]  cur;
        seen = '0;
        cur = start;
        for (int n = 0; n <= TXNS; n++)
        begin
            if (cur == req)
                return 1'b1;
            if (seen[cur] || !edge_on[cur])
                return 1'b0;
            seen[cur] = 1'b1;
            cur = edge_to[cur];
        end
        return 1'b0;
    endfunction

    function automatic logic [3:0] lowest_txn(logic [15:0] m);
        for (int i = 0; i < TXNS; i++)
            if (m[i])
                return i[3:0];
        return 4'd0;
    endfunction

    // Append one answer at the tail of the pending list.
    task automatic queue_answer(lock_answer_t a);
        answers_due.insert(answers_due.size(), a);
    endtask

    // Apply one request to the predictor and queue its answer, if any.
    task automatic predict_lock(logic [1:0] op, logic [31:0] key, logic [3:0] req);
        lock_answer_t a;
        logic [15:0] rbit;
        int hit;
        int spare;
        bit clash;
        if (op != rlt_pkg::OP_EXCL && op != rlt_pkg::OP_SHARED && op != rlt_pkg::OP_RELEASE)
            return;
        rbit = 16'd1 << req;
        a.status = rlt_pkg::ST_GRANTED;
        a.holder = 4'd0;
        clash = 1'b0;
        if (op == rlt_pkg::OP_RELEASE)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i])
                begin
                    slot_holders[i] &= ~rbit;
                    if (slot_holders[i] == 0)
                        slot_used[i] = 1'b0;
                end
            for (int t = 0; t < TXNS; t++)
                if (t == req || (edge_on[t] && edge_to[t] == req))
                    edge_on[t] = 1'b0;
            a.status = rlt_pkg::ST_RELEASED;
            queue_answer(a);
            return;
        end
        hit = -1;
        spare = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_key[i] == key)
                hit = i;
            if (!slot_used[i])
                spare = i;
        end
        if (hit < 0)
        begin
            if (spare < 0)
                a.status = rlt_pkg::ST_FULL;
            else
            begin
                slot_used[spare] = 1'b1;
                slot_key[spare] = key;
                slot_excl[spare] = (op == rlt_pkg::OP_EXCL);
                slot_holders[spare] = rbit;
            end
        end
        else if (slot_excl[hit])
        begin
            if (slot_holders[hit] != rbit)
            begin
                clash = 1'b1;
                a.holder = lowest_txn(slot_holders[hit]);
            end
        end
        else if (op == rlt_pkg::OP_EXCL)
        begin
            if (slot_holders[hit] == rbit)
                slot_excl[hit] = 1'b1;
            else
            begin
                clash = 1'b1;
                a.holder = lowest_txn(slot_holders[hit] & ~rbit);
            end
        end
        else
            slot_holders[hit] |= rbit;
        if (clash)
        begin
            if (chain_reaches(req, a.holder))
                a.status = rlt_pkg::ST_DEADLOCK;
            else
            begin
                edge_on[req] = 1'b1;
                edge_to[req] = a.holder;
                a.status = rlt_pkg::ST_CONFLICT;
            end
        end
        queue_answer(a);
    endtask

    // Send one request, with an optional random gap before it.
    task automatic send_request(logic [1:0] op, logic [31:0] key, logic [3:0] req);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, req, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_lock(op, key, req);
    endtask

    task automatic release_all();
        for (int t = 0; t < TXNS; t++)
            send_request(rlt_pkg::OP_RELEASE, $urandom, t[3:0]);
    endtask

    // Extremes of the fields, all opcodes, ignored requests, upgrade and conflicts.
    task automatic test_directed();
        send_request(rlt_pkg::OP_EXCL, 32'h0000_0000, 4'd0);
        send_request(rlt_pkg::OP_EXCL, 32'h0000_0000, 4'd0);      // re-entry
        send_request(rlt_pkg::OP_SHARED, 32'h0000_0000, 4'd15);   // conflict on exclusive
        send_request(rlt_pkg::OP_SHARED, 32'hFFFF_FFFF, 4'd15);
        send_request(rlt_pkg::OP_SHARED, 32'hFFFF_FFFF, 4'd3);
        send_request(rlt_pkg::OP_SHARED, 32'hFFFF_FFFF, 4'd9);    // several shared holders
        send_request(rlt_pkg::OP_EXCL, 32'hFFFF_FFFF, 4'd15);     // lowest foreign holder
        send_request(rlt_pkg::OP_EXCL, 32'hFFFF_FFFF, 4'd0);      // conflict with the shared holders
        send_request(rlt_pkg::OP_NONE, 32'h1234_5678, 4'd1);      // unknown opcode, ignored
        send_request(rlt_pkg::OP_RELEASE, 32'hA5A5_5A5A, 4'd9);
        send_request(rlt_pkg::OP_RELEASE, 32'h5A5A_A5A5, 4'd3);
        send_request(rlt_pkg::OP_EXCL, 32'hFFFF_FFFF, 4'd15);     // upgrade by sole holder
        send_request(rlt_pkg::OP_RELEASE, 32'h0, 4'd7);           // idle transaction
        release_all();
    endtask

    // Fill every slot, then ask for one more row.
    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            send_request(i[0] ? rlt_pkg::OP_SHARED : rlt_pkg::OP_EXCL, 32'h100 + i, i[3:0]);
        send_request(rlt_pkg::OP_EXCL, 32'hDEAD_BEEF, 4'd5);
        send_request(rlt_pkg::OP_SHARED, 32'h100, 4'd1);
        release_all();
    endtask

    // Random traffic on a small key pool, releases mixed in.
    task automatic test_random(int count);
        int r;
        logic [31:0] k;
        logic [3:0]  t;
        for (int n = 0; n < count; n++)
        begin
            if (n % 200 == 0)
                foreach (key_pool[i])
                    key_pool[i] = $urandom;
            r = $urandom_range(0, 99);
            k = (r < 90) ? key_pool[$urandom_range(0, 7)] : $urandom;
            t = 4'($urandom_range(0, 15));
            if (r < 40)
                send_request(rlt_pkg::OP_EXCL, k, t);
            else if (r < 80)
                send_request(rlt_pkg::OP_SHARED, k, t);
            else if (r < 97)
                send_request(rlt_pkg::OP_RELEASE, k, t);
            else
                send_request(rlt_pkg::OP_NONE, k, t);
        end
    endtask

    // Result checker with random back-pressure and stall bursts.
    always @(posedge clk)
    begin
        lock_answer_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with no request pending: status %0d holder %0d",
                           m_tdata[2:0], m_tdata[6:3]);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[6:3] !== want.holder)
                    begin
                        $error("blocking_holder: expected %0d, got %0d",
                               want.holder, m_tdata[6:3]);
                        fail_count++;
                    end
                end
            end
            if (calm)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 40) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else if ($urandom_range(0, 5) != 0)
                m_tready <= 1'b1;
            else
                m_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        stall_left = 0;
        calm = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        for (int t = 0; t < TXNS; t++)
            edge_on[t] = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random(1000);
        calm = 1'b1;
        test_random(150);
        s_tvalid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
